@@ src/arfp_pkg.sv @@
// Package for the ASCII range frame parser: frame geometry, register codes,
// digit storage type and the decimal digit weights.
// No dependencies.
`default_nettype none

package arfp_pkg;

  // Frame geometry.
  localparam int BUFFER_LENGTH = 200;
  localparam int DIGIT_START   = 10;
  localparam int DIGIT_COUNT   = 5;
  localparam int MATCH_POS_A   = 4;
  localparam int MATCH_POS_B   = 5;

  // Field and register widths.
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [VALUE_W-1:0] ASCII_ZERO = 16'h0030;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHAR    = 3'd0,
    REG_END_CHAR      = 3'd1,
    REG_MATCH_FIRST   = 3'd2,
    REG_MATCH_SECOND  = 3'd3,
    REG_STOP_DISTANCE = 3'd4
  } cfg_reg_e;

  // Register reset values.
  localparam logic [BYTE_W-1:0]  START_CHAR_RST    = 8'd42;
  localparam logic [BYTE_W-1:0]  END_CHAR_RST      = 8'd35;
  localparam logic [BYTE_W-1:0]  MATCH_FIRST_RST   = 8'd54;
  localparam logic [BYTE_W-1:0]  MATCH_SECOND_RST  = 8'd52;
  localparam logic [VALUE_W-1:0] STOP_DISTANCE_RST = 16'd400;

  // Captured digit characters, most significant first.
  typedef logic [DIGIT_COUNT-1:0][BYTE_W-1:0] digits_t;

  // Weight of digit k: 10000 for the first digit, falling by tens.
  function automatic logic [VALUE_W-1:0] digit_weight(input int k);
    logic [VALUE_W-1:0] w;
    case (k)
      0:       w = 16'd10000;
      1:       w = 16'd1000;
      2:       w = 16'd100;
      3:       w = 16'd10;
      4:       w = 16'd1;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/ascii_range_frame_parser.sv @@
// The end character of a matching frame loads the snapshot stage, which then
// loads the output stage. Throughput: one byte per cycle; a byte is refused
// only while a result waits in both the snapshot and output stages.
// Reset (asynchronous, active low) clears the frame state, the kept bytes and
// the stage valids, and loads the register defaults. Uses arfp_pkg.
`default_nettype none

module ascii_range_frame_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [arfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [arfp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Byte input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [arfp_pkg::BYTE_W-1:0]       rx_byte_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [arfp_pkg::VALUE_W-1:0]      distance_o,
  output logic [arfp_pkg::VALUE_W-1:0]      remaining_o
);
  import arfp_pkg::*;

  // Configuration registers.
  logic [BYTE_W-1:0]  start_char_q, end_char_q, match_first_q, match_second_q;
  logic [VALUE_W-1:0] stop_distance_q;

  // Frame state.
  logic              in_frame_q, in_frame_d;
  logic [POS_W-1:0]  position_q, position_d;
  logic [BYTE_W-1:0] match_a_q, match_a_d, match_b_q, match_b_d;
  digits_t           digits_q, digits_d;

  // Snapshot stage and output stage.
  logic              snap_valid_q;
  digits_t           snap_digits_q;
  logic              out_valid_q;
  logic [VALUE_W-1:0] distance_q, remaining_q;
  logic [VALUE_W-1:0] calc_distance, calc_remaining;

  logic in_xfer, snap_adv, is_start, is_end, emit;
  logic [POS_W-1:0] pos_base;
  logic [POS_W:0]   pos_inc;

  // Handshake: the snapshot moves on when the output register is free or
  // drained in this cycle; bytes are taken unless the snapshot is stuck.
  assign snap_adv   = !out_valid_q || out_ready_i;
  assign in_ready_o = !snap_valid_q || snap_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q    <= START_CHAR_RST;
      end_char_q      <= END_CHAR_RST;
      match_first_q   <= MATCH_FIRST_RST;
      match_second_q  <= MATCH_SECOND_RST;
      stop_distance_q <= STOP_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_START_CHAR:    start_char_q    <= cfg_wdata_i[BYTE_W-1:0];
        REG_END_CHAR:      end_char_q      <= cfg_wdata_i[BYTE_W-1:0];
        REG_MATCH_FIRST:   match_first_q   <= cfg_wdata_i[BYTE_W-1:0];
        REG_MATCH_SECOND:  match_second_q  <= cfg_wdata_i[BYTE_W-1:0];
        REG_STOP_DISTANCE: stop_distance_q <= cfg_wdata_i[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame decode: the end check uses the bytes kept before this byte.
  assign is_end   = (rx_byte_i == end_char_q);
  assign is_start = (rx_byte_i == start_char_q);
  assign emit     = is_end && (match_a_q == match_first_q) && (match_b_q == match_second_q);
  assign pos_base = is_start ? '0 : position_q;
  assign pos_inc  = {1'b0, pos_base} + (POS_W+1)'(1);

  // Next frame state: store by position, advance and wrap at the buffer end.
  always_comb begin
    in_frame_d = in_frame_q;
    position_d = position_q;
    match_a_d  = match_a_q;
    match_b_d  = match_b_q;
    digits_d   = digits_q;
    if (is_end) begin
      in_frame_d = 1'b0;
    end
    if (is_start) begin
      in_frame_d = 1'b1;
      position_d = '0;
    end
    if (in_frame_d) begin
      if (pos_base == POS_W'(MATCH_POS_A)) begin
        match_a_d = rx_byte_i;
      end
      if (pos_base == POS_W'(MATCH_POS_B)) begin
        match_b_d = rx_byte_i;
      end
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        if (pos_base == POS_W'(DIGIT_START + k)) begin
          digits_d[k] = rx_byte_i;
        end
      end
      if (pos_inc >= (POS_W+1)'(BUFFER_LENGTH)) begin
        position_d = '0;
      end else begin
        position_d = pos_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      position_q <= '0;
      match_a_q  <= '0;
      match_b_q  <= '0;
      digits_q   <= '0;
    end else if (in_xfer) begin
      in_frame_q <= in_frame_d;
      position_q <= position_d;
      match_a_q  <= match_a_d;
      match_b_q  <= match_b_d;
      digits_q   <= digits_d;
    end
  end

  // Snapshot stage: holds the digits of a matching frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_xfer) begin
      snap_valid_q <= emit;
    end else if (snap_adv) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      snap_digits_q <= digits_q;
    end
  end

  arfp_value_calc u_value_calc (
    .digits_i        (snap_digits_q),
    .stop_distance_i (stop_distance_q),
    .distance_o      (calc_distance),
    .remaining_o     (calc_remaining)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_adv) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv && snap_valid_q) begin
      distance_q  <= calc_distance;
      remaining_q <= calc_remaining;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;
  assign remaining_o = remaining_q;

endmodule

`default_nettype wire

@@ src/arfp_value_calc.sv @@
// Converts the captured digit characters into the decimal distance and the
// remaining distance, both modulo 2^16. Uses arfp_pkg.
`default_nettype none

module arfp_value_calc (
  input  arfp_pkg::digits_t              digits_i,
  input  logic [arfp_pkg::VALUE_W-1:0]   stop_distance_i,
  output logic [arfp_pkg::VALUE_W-1:0]   distance_o,
  output logic [arfp_pkg::VALUE_W-1:0]   remaining_o
);
  import arfp_pkg::*;

  logic [VALUE_W-1:0] sum;

  // Each digit is offset from ASCII zero and scaled by a constant weight.
  // Non-digit characters go through the same formula and the sum wraps.
  always_comb begin
    sum = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      sum = VALUE_W'(sum + VALUE_W'(({{(VALUE_W-BYTE_W){1'b0}}, digits_i[k]} - ASCII_ZERO)
                                    * digit_weight(k)));
    end
  end

  assign distance_o  = sum;
  assign remaining_o = VALUE_W'(sum - stop_distance_i);

endmodule

`default_nettype wire

@@ src/arfp_checker.sv @@
// Port-level checker for the ASCII range frame parser, bound to the top level.
// Uses arfp_pkg for widths.
`default_nettype none

module arfp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [arfp_pkg::VALUE_W-1:0]    distance_o,
  input logic [arfp_pkg::VALUE_W-1:0]    remaining_o
);

  // A stalled result keeps its valid and its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(distance_o) && $stable(remaining_o))
    else $error("result changed while stalled");

  // Bytes are refused only while a result is stalled at the output.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without output stall");

  // A fresh result follows a byte transfer through the snapshot and output stages.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a preceding byte transfer");

  // No result is shown during reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind ascii_range_frame_parser arfp_checker u_arfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o),
  .remaining_o (remaining_o)
);

`default_nettype wire
